[rtl/core/mcfi_pkg.sv]
package mcfi_pkg;

  localparam int unsigned CAMERAS          = 24;
  localparam int unsigned PIXELS_PER_FRAME = 4096;
  localparam int unsigned FRAMES_TO_SUM    = 8;
  localparam int unsigned TRY_FACTOR       = 10;
  localparam int unsigned TRY_LIMIT        = TRY_FACTOR * CAMERAS * FRAMES_TO_SUM;

  localparam int unsigned CAM_W   = 5;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned OPOS_W  = 12;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CIDX_W  = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int unsigned POS_W   = $clog2(PIXELS_PER_FRAME);
  localparam int unsigned ACC_DEPTH = CAMERAS * PIXELS_PER_FRAME;
  localparam int unsigned ADDR_W  = $clog2(ACC_DEPTH);
  localparam int unsigned TRY_W   = $clog2(TRY_LIMIT + 1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CAM_W-1:0]  cam;
    logic [POS_W-1:0]  pos;
    logic [PIX_W-1:0]  pix;
    logic              write;
    logic              first;
    logic              emit;
    logic              fend;
    logic              done;
    logic              quit;
  } item_t;

  typedef struct packed {
    logic [CAM_W-1:0]  out_camera;
    logic [OPOS_W-1:0] position;
    logic [SUM_W-1:0]  sum;
    logic              last;
    logic              all_done;
    logic              gave_up;
  } result_t;

endpackage

[rtl/core/mcfi_acc.sv]
module mcfi_acc (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mcfi_pkg::item_t in_item_i,
  input  logic            adv_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output mcfi_pkg::result_t res_o
);
  import mcfi_pkg::*;

  logic [SUM_W-1:0]  mem_q [ACC_DEPTH];
  logic [SUM_W-1:0]  rdata_q;
  logic              s1_valid_q, s1_valid_d;
  item_t             s1_q;
  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [SUM_W-1:0]  fwd_data_q;
  logic [SUM_W-1:0]  old_sum;
  logic [SUM_W-1:0]  total;
  logic              wr_en;

  // read on entry, write back as the item leaves
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      rdata_q <= mem_q[in_item_i.addr];
    end
    if (wr_en) begin
      mem_q[s1_q.addr] <= total;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i) begin
      s1_valid_d = 1'b1;
    end else if (adv_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (wr_en) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_q <= in_item_i;
    end
    if (wr_en) begin
      fwd_addr_q <= s1_q.addr;
      fwd_data_q <= total;
    end
  end

  // last write may have raced this item's read
  assign old_sum = (fwd_valid_q && (fwd_addr_q == s1_q.addr)) ? fwd_data_q : rdata_q;
  assign total   = s1_q.first ? SUM_W'(s1_q.pix) : old_sum + SUM_W'(s1_q.pix);
  assign wr_en   = s1_valid_q && adv_i && s1_q.write;

  assign busy_o      = s1_valid_q;
  assign res_valid_o = s1_valid_q && (s1_q.emit || s1_q.done || s1_q.quit);

  always_comb begin
    res_o            = '0;
    res_o.all_done   = s1_q.done;
    res_o.gave_up    = s1_q.quit;
    if (s1_q.emit) begin
      res_o.out_camera = s1_q.cam;
      res_o.position   = OPOS_W'(s1_q.pos);
      res_o.sum        = total;
      res_o.last       = s1_q.fend;
    end
  end

endmodule

[rtl/core/multi_camera_frame_integrator.sv]
// datapath: accepted pixel -> accumulator stage register -> output register
// throughput: one item per cycle unless the output stalls, set by the registered
//   read and write-back of the accumulator, forwarding back-to-back hits on one word
// reset: counts, try counter, position, finish flag and target tag clear at once;
//   the accumulator memory is not cleared, the first summed frame overwrites it
module multi_camera_frame_integrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          target_tag_we_i,
  input  logic [mcfi_pkg::TAG_W-1:0]    target_tag_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [mcfi_pkg::CAM_W-1:0]    camera_i,
  input  logic [mcfi_pkg::TAG_W-1:0]    tag_i,
  input  logic [mcfi_pkg::PIX_W-1:0]    pixel_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mcfi_pkg::CAM_W-1:0]    out_camera_o,
  output logic [mcfi_pkg::OPOS_W-1:0]   position_o,
  output logic [mcfi_pkg::SUM_W-1:0]    sum_o,
  output logic                          last_o,
  output logic                          all_done_o,
  output logic                          gave_up_o
);
  import mcfi_pkg::*;

  logic [TAG_W-1:0] target_tag_q;
  logic [CNT_W-1:0] counts_q [CAMERAS];
  logic [CNT_W-1:0] counts_d [CAMERAS];
  logic [TRY_W-1:0] tries_q, tries_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             finished_q, finished_d;

  logic              in_acc, pix_go, cam_ok, accept, every_done, quit;
  logic [CAM_W-1:0]  cam_m1;
  logic [CIDX_W-1:0] cidx;
  logic [CNT_W-1:0]  cnt_sel;
  logic [TRY_W:0]    tries_inc;
  item_t             item;

  logic    acc_busy, res_valid, adv;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = acc_busy && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_go     = in_acc && (op_e'(op_i) == OP_PIXEL) && !finished_q;

  assign cam_ok  = (camera_i >= CAM_W'(1)) && (camera_i <= CAM_W'(CAMERAS));
  assign cam_m1  = camera_i - CAM_W'(1);
  assign cidx    = cam_m1[CIDX_W-1:0];
  assign cnt_sel = cam_ok ? counts_q[cidx] : '0;
  assign accept  = cam_ok && (tag_i == target_tag_q) && (cnt_sel < CNT_W'(FRAMES_TO_SUM));
  assign tries_inc = {1'b0, tries_q} + 1'b1;

  always_comb begin
    every_done = 1'b1;
    for (int c = 0; c < CAMERAS; c++) begin
      counts_d[c] = counts_q[c];
      if (accept && frame_end_i && (cidx == CIDX_W'(c))) begin
        counts_d[c] = counts_q[c] + 1'b1;
      end
      if (counts_d[c] < CNT_W'(FRAMES_TO_SUM)) begin
        every_done = 1'b0;
      end
    end
    quit = !every_done && (tries_inc >= (TRY_W+1)'(TRY_LIMIT));
  end

  always_comb begin
    tries_d    = tries_q;
    pos_d      = pos_q;
    finished_d = finished_q;
    if (in_acc && (op_e'(op_i) == OP_START)) begin
      tries_d    = '0;
      pos_d      = '0;
      finished_d = 1'b0;
    end else if (pix_go) begin
      if (frame_end_i) begin
        pos_d      = '0;
        tries_d    = tries_inc[TRY_W-1:0];
        finished_d = every_done || quit;
      end else if ((32'(pos_q) + 32'd1) >= 32'(PIXELS_PER_FRAME)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    item       = '0;
    item.addr  = ADDR_W'(cidx) * ADDR_W'(PIXELS_PER_FRAME) + ADDR_W'(pos_q);
    item.cam   = camera_i;
    item.pos   = pos_q;
    item.pix   = pixel_i;
    item.write = accept;
    item.first = (cnt_sel == '0);
    item.emit  = accept && (cnt_sel == CNT_W'(FRAMES_TO_SUM - 1));
    item.fend  = frame_end_i;
    item.done  = frame_end_i && every_done;
    item.quit  = frame_end_i && quit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_tag_q <= '0;
      tries_q      <= '0;
      pos_q        <= '0;
      finished_q   <= 1'b0;
      for (int c = 0; c < CAMERAS; c++) begin
        counts_q[c] <= '0;
      end
    end else begin
      if (target_tag_we_i) begin
        target_tag_q <= target_tag_i;
      end
      tries_q    <= tries_d;
      pos_q      <= pos_d;
      finished_q <= finished_d;
      for (int c = 0; c < CAMERAS; c++) begin
        if (in_acc && (op_e'(op_i) == OP_START)) begin
          counts_q[c] <= '0;
        end else if (pix_go) begin
          counts_q[c] <= counts_d[c];
        end
      end
    end
  end

  mcfi_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_go),
    .in_item_i   (item),
    .adv_i       (adv),
    .busy_o      (acc_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_camera_o = out_q.out_camera;
  assign position_o   = out_q.position;
  assign sum_o        = out_q.sum;
  assign last_o       = out_q.last;
  assign all_done_o   = out_q.all_done;
  assign gave_up_o    = out_q.gave_up;

endmodule
